// ===== src/fasc_pkg.sv =====
// Package for the flap actuator state controller: request and result types,
// state encoding, field codes, configuration layout and reset values.
// No dependencies.
`default_nettype none

package fasc_pkg;

	typedef enum logic [2:0] {
		ST_CLOSING       = 3'd0,
		ST_CLOSED_EMPTY  = 3'd1,
		ST_CLOSED_PACKET = 3'd2,
		ST_STAGING       = 3'd3,
		ST_OPENING       = 3'd4,
		ST_OPEN          = 3'd5,
		ST_STOP          = 3'd6,
		ST_ERROR         = 3'd7
	} state_t;

	localparam logic [1:0] EDGE_FEED     = 2'd1;
	localparam logic [2:0] MOTOR_RUNNING = 3'd2;
	localparam logic [1:0] POS_UNKNOWN   = 2'd0;
	localparam logic [1:0] POS_CLOSED    = 2'd1;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_DROP_STATION   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_OPEN_TIMEOUT   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_CLOSE_DETECT   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_SWEEP_THRESH   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_CARRIER_OPEN   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_CLOSING_TIMEOUT = 3'd5;

	localparam logic [7:0]  RST_DROP_STATION    = 8'd1;
	localparam logic [15:0] RST_OPEN_TIMEOUT    = 16'd1000;
	localparam logic [15:0] RST_CLOSE_DETECT    = 16'd50;
	localparam logic [15:0] RST_SWEEP_THRESH    = 16'd100;
	localparam logic [15:0] RST_CARRIER_OPEN    = 16'd300;
	localparam logic [15:0] RST_CLOSING_TIMEOUT = 16'd1000;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [31:0] switch_hold_ms;
		logic [1:0]  edge_now;
		logic [1:0]  edge_before;
		logic [2:0]  motor_mode;
		logic [31:0] sweep_ms;
		logic [7:0]  station_now;
		logic        system_error;
		logic        flap_error;
	} in_t;

	typedef struct packed {
		logic [2:0] flap_state;
		logic       state_changed;
		logic [1:0] position_cmd;
		logic       magnets_on;
		logic       torque_off;
		logic       dropoff_request;
		logic       closed_now;
		logic       infeed_stop;
	} out_t;

	typedef struct packed {
		logic [7:0]  drop_station;
		logic [15:0] open_timeout_ms;
		logic [15:0] close_detect_ms;
		logic [15:0] sweep_threshold_ms;
		logic [15:0] carrier_open_ms;
		logic [15:0] closing_timeout_ms;
	} cfg_t;

	// controller state carried from tick to tick
	typedef struct packed {
		state_t      fsm;
		logic        infeed_stop;
		logic [31:0] open_time;
		logic [31:0] opening_start;
		logic [1:0]  position;
		logic        magnets;
		logic        torque_off;
		logic        dropoff;
	} ctx_t;

endpackage

`default_nettype wire

// ===== src/fasc_step.sv =====
// One control tick: closed flag, infeed-stop flag, flap state transition
// and entry actions. Purely combinational. Depends on fasc_pkg.
`default_nettype none

module fasc_step
	import fasc_pkg::*;
(
	input  in_t  req,
	input  cfg_t cfg,
	input  ctx_t cur,
	output ctx_t nxt,
	output out_t res
);

	logic        closed;
	logic        infeed;
	logic        changed;
	logic        at_drop;
	logic [31:0] since_open;
	logic [31:0] since_opening;
	state_t      ns;

	assign closed        = req.switch_hold_ms > {16'd0, cfg.close_detect_ms};
	assign since_open    = req.now_ms - cur.open_time;
	assign since_opening = req.now_ms - cur.opening_start;
	assign at_drop       = req.station_now == cfg.drop_station;

	// clearing on leaving the infeed edge wins over setting
	always_comb begin
		infeed = cur.infeed_stop;
		if (req.edge_now == EDGE_FEED && req.sweep_ms > {16'd0, cfg.sweep_threshold_ms}
				&& req.motor_mode == MOTOR_RUNNING) begin
			infeed = 1'b1;
		end
		if (req.edge_before == EDGE_FEED && req.edge_now != EDGE_FEED) begin
			infeed = 1'b0;
		end
	end

	always_comb begin
		ns = cur.fsm;
		priority if (cur.fsm == ST_ERROR) begin
			if (!req.flap_error) ns = ST_STOP;
		end else if (req.flap_error) begin
			ns = ST_ERROR;
		end else if (cur.fsm == ST_STOP) begin
			priority if (req.system_error) begin
				ns = ST_STOP;
			end else if (since_open > {16'd0, cfg.open_timeout_ms} && !closed) begin
				ns = ST_CLOSING;
			end else if (closed && !infeed) begin
				ns = ST_CLOSED_EMPTY;
			end else if (closed && req.edge_now == EDGE_FEED && infeed) begin
				ns = ST_CLOSED_PACKET;
			end else if (at_drop) begin
				ns = ST_OPENING;
			end else begin
				ns = ST_STOP;
			end
		end else if (req.system_error) begin
			ns = ST_STOP;
		end else begin
			unique case (cur.fsm)
				ST_CLOSING:       if (closed && !infeed) ns = ST_CLOSED_EMPTY;
				ST_CLOSED_EMPTY:  if (closed && infeed) ns = ST_CLOSED_PACKET;
				ST_CLOSED_PACKET: if (at_drop) ns = ST_OPENING;
				ST_OPENING: begin
					if (since_opening > {16'd0, cfg.carrier_open_ms}) ns = ST_OPEN;
				end
				ST_OPEN: begin
					if (since_opening > {16'd0, cfg.closing_timeout_ms}) ns = ST_CLOSING;
				end
				default: ns = cur.fsm;
			endcase
		end
	end

	assign changed = ns != cur.fsm;

	always_comb begin
		nxt             = cur;
		nxt.fsm         = ns;
		nxt.infeed_stop = infeed;
		if (changed) begin
			unique case (ns)
				ST_ERROR, ST_STOP: begin
					nxt.torque_off = 1'b1;
					nxt.magnets    = 1'b1;
				end
				ST_CLOSING: begin
					nxt.position = POS_CLOSED;
					nxt.magnets  = 1'b1;
				end
				ST_CLOSED_EMPTY: nxt.dropoff = 1'b1;
				ST_OPENING: begin
					nxt.magnets       = 1'b0;
					nxt.opening_start = req.now_ms;
				end
				ST_OPEN: nxt.open_time = req.now_ms;
				default: ;
			endcase
		end
	end

	always_comb begin
		res.flap_state      = nxt.fsm;
		res.state_changed   = changed;
		res.position_cmd    = nxt.position;
		res.magnets_on      = nxt.magnets;
		res.torque_off      = nxt.torque_off;
		res.dropoff_request = nxt.dropoff;
		res.closed_now      = closed;
		res.infeed_stop     = infeed;
	end

endmodule

`default_nettype wire

// ===== src/flap_actuator_state_controller.sv =====
// Flap actuator state controller, top level: request register, tick logic,
// result register and configuration registers. Depends on fasc_pkg, fasc_step.
// Each accepted request is one control tick and yields exactly one result.
// A request is taken every cycle when the result side keeps up; the request
// register loads on acceptance and the result register when the tick
// advances, which waits while a held result is not taken. The rate is set by
// the combinational update of the controller state from the registered
// request. Configuration writes take effect on the next tick and must be
// made while the block is idle.
`default_nettype none

module flap_actuator_state_controller
	import fasc_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  in_t                 in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output out_t                out_data,
	input  wire                 cfg_we,
	input  wire [CfgIdxW-1:0]   cfg_index,
	input  wire [CfgDataW-1:0]  cfg_data
);

	in_t  req_s1;
	logic vld_s1;
	out_t res_q;
	logic res_vld_q;
	ctx_t ctx_q;
	cfg_t cfg_q;
	ctx_t ctx_nxt;
	out_t res_nxt;
	logic advance;

	assign advance  = vld_s1 && (!res_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	fasc_step u_step (
		.req (req_s1),
		.cfg (cfg_q),
		.cur (ctx_q),
		.nxt (ctx_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) req_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (out_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.fsm           <= ST_STOP;
			ctx_q.infeed_stop   <= 1'b0;
			ctx_q.open_time     <= 32'd0;
			ctx_q.opening_start <= 32'd0;
			ctx_q.position      <= POS_UNKNOWN;
			ctx_q.magnets       <= 1'b1;
			ctx_q.torque_off    <= 1'b0;
			ctx_q.dropoff       <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drop_station       <= RST_DROP_STATION;
			cfg_q.open_timeout_ms    <= RST_OPEN_TIMEOUT;
			cfg_q.close_detect_ms    <= RST_CLOSE_DETECT;
			cfg_q.sweep_threshold_ms <= RST_SWEEP_THRESH;
			cfg_q.carrier_open_ms    <= RST_CARRIER_OPEN;
			cfg_q.closing_timeout_ms <= RST_CLOSING_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DROP_STATION:    cfg_q.drop_station       <= cfg_data[7:0];
				CFG_OPEN_TIMEOUT:    cfg_q.open_timeout_ms    <= cfg_data;
				CFG_CLOSE_DETECT:    cfg_q.close_detect_ms    <= cfg_data;
				CFG_SWEEP_THRESH:    cfg_q.sweep_threshold_ms <= cfg_data;
				CFG_CARRIER_OPEN:    cfg_q.carrier_open_ms    <= cfg_data;
				CFG_CLOSING_TIMEOUT: cfg_q.closing_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid = res_vld_q;
	assign out_data  = res_q;

endmodule

`default_nettype wire

// ===== src/fasc_checker.sv =====
// Port-level checks for the flap actuator state controller and the bind
// that attaches them to the top level. Depends on fasc_pkg.
`default_nettype none

module fasc_checker
	import fasc_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_ready,
	input out_t               out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.torque_off && out_data.dropoff_request
		|=> !out_valid || (out_data.torque_off && out_data.dropoff_request))
		else $error("sticky request flag dropped");

	a_no_staging: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.flap_state != ST_STAGING)
		else $error("staging state reported");

	a_closing_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.state_changed && out_data.flap_state == ST_CLOSING
		|-> out_data.position_cmd == POS_CLOSED && out_data.magnets_on)
		else $error("closing entry actions missing");

endmodule

bind flap_actuator_state_controller fasc_checker u_fasc_checker (.*);

`default_nettype wire

// ===== dv/tb_flap_actuator_state_controller.sv =====
// Self-checking testbench for the flap actuator state controller: a directed table,
// then random ticks under several configurations, checked against the table's expected
// values where given, else against an in-bench model. Depends on fasc_pkg and flap_actuator_state_controller.
`timescale 1ns / 1ps

module tb_flap_actuator_state_controller
	import fasc_pkg::*;
;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLDOFF_CYC = 300;
	localparam int N_PHASES    = 8;
	localparam int PHASE_TICKS = 250;
	localparam int MAX_REPORTS = 200;

	localparam logic [1:0] EDGE_NONE   = 2'd0;
	localparam logic [1:0] EDGE_MAIN   = 2'd2;
	localparam logic [1:0] EDGE_UNUSED = 2'd3;

	localparam logic [2:0] MOTOR_STOP     = 3'd0;
	localparam logic [2:0] MOTOR_SWEEPING = 3'd3;
	localparam logic [2:0] MOTOR_ERROR    = 3'd4;
	localparam logic [2:0] MOTOR_UNUSED_A = 3'd5;
	localparam logic [2:0] MOTOR_UNUSED_B = 3'd7;

	typedef struct packed {
		in_t  req;
		logic typed;
		out_t exp;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_t                 in_data;
	logic                out_valid;
	logic                out_ready;
	out_t                out_data;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// model of the controller
	cfg_t        cfg_m;
	state_t      m_state;
	logic        m_infeed;
	logic [31:0] m_open_t;
	logic [31:0] m_opening_t;
	logic [1:0]  m_pos;
	logic        m_mag;
	logic        m_torq;
	logic        m_drop;

	out_t     pending_status[$];
	dir_row_t dir_tab[$];

	logic        req_typed;
	out_t        req_exp;
	logic        stall_req;
	logic [31:0] sim_ms;
	int          gap_burst;
	int          n_fail;
	int          n_ticks;
	int          n_results;
	int          n_cfg;
	int          cyc;
	logic [7:0]  states_seen;
	out_t        want;
	out_t        predicted;

	flap_actuator_state_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cyc,
			pending_status.size());
		$display("tb_flap_actuator_state_controller failed");
		$finish;
	end

	function automatic out_t flap_tick(input in_t r);
		out_t        o;
		state_t      nxt;
		logic        closed;
		logic        chg;
		logic [31:0] since_open;
		logic [31:0] since_opening;
		closed        = r.switch_hold_ms > cfg_m.close_detect_ms;
		since_open    = r.now_ms - m_open_t;
		since_opening = r.now_ms - m_opening_t;
		nxt           = m_state;

		// set first, then clear on leaving the infeed edge
		if (r.edge_now == EDGE_FEED && r.sweep_ms > cfg_m.sweep_threshold_ms &&
				r.motor_mode == MOTOR_RUNNING)
			m_infeed = 1'b1;
		if (r.edge_before == EDGE_FEED && r.edge_now != EDGE_FEED)
			m_infeed = 1'b0;

		if (m_state == ST_ERROR) begin
			if (!r.flap_error)
				nxt = ST_STOP;
		end else if (r.flap_error) begin
			nxt = ST_ERROR;
		end else if (m_state == ST_STOP) begin
			if (!r.system_error) begin
				if (since_open > cfg_m.open_timeout_ms && !closed) begin
					nxt = ST_CLOSING;
				end else if (closed && !m_infeed) begin
					nxt = ST_CLOSED_EMPTY;
				end else if (closed && r.edge_now == EDGE_FEED && m_infeed) begin
					nxt = ST_CLOSED_PACKET;
				end else if (r.station_now == cfg_m.drop_station) begin
					nxt         = ST_OPENING;
					m_opening_t = r.now_ms;
				end
			end
		end else if (r.system_error) begin
			nxt = ST_STOP;
		end else begin
			case (m_state)
				ST_CLOSING: begin
					if (closed && !m_infeed)
						nxt = ST_CLOSED_EMPTY;
				end
				ST_CLOSED_EMPTY: begin
					if (closed && m_infeed)
						nxt = ST_CLOSED_PACKET;
				end
				ST_CLOSED_PACKET: begin
					if (r.station_now == cfg_m.drop_station) begin
						nxt         = ST_OPENING;
						m_opening_t = r.now_ms;
					end
				end
				ST_OPENING: begin
					if (since_opening > cfg_m.carrier_open_ms) begin
						nxt      = ST_OPEN;
						m_open_t = r.now_ms;
					end
				end
				ST_OPEN: begin
					if (since_opening > cfg_m.closing_timeout_ms)
						nxt = ST_CLOSING;
				end
				default: ;
			endcase
		end

		chg     = (nxt != m_state);
		m_state = nxt;
		// entry actions only on a real transition
		if (chg) begin
			case (nxt)
				ST_ERROR, ST_STOP: begin
					m_torq = 1'b1;
					m_mag  = 1'b1;
				end
				ST_CLOSING: begin
					m_pos = POS_CLOSED;
					m_mag = 1'b1;
				end
				ST_CLOSED_EMPTY: m_drop = 1'b1;
				ST_OPENING:      m_mag  = 1'b0;
				default: ;
			endcase
		end

		o.flap_state      = m_state;
		o.state_changed   = chg;
		o.position_cmd    = m_pos;
		o.magnets_on      = m_mag;
		o.torque_off      = m_torq;
		o.dropoff_request = m_drop;
		o.closed_now      = closed;
		o.infeed_stop     = m_infeed;
		return o;
	endfunction

	task automatic check_field(input string fname, input logic [2:0] exp_v,
			input logic [2:0] got_v);
		if (got_v !== exp_v) begin
			n_fail++;
			if (n_fail <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname,
					exp_v, got_v);
		end
	endtask

	// result checking first, then prediction for a request taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				states_seen[out_data.flap_state] = 1'b1;
				if (pending_status.size() == 0) begin
					n_fail++;
					$display("%0t ns: unexpected result, expected none, got %h", $time,
						out_data);
				end else begin
					want = pending_status.pop_front();
					check_field("flap_state", want.flap_state, out_data.flap_state);
					check_field("state_changed", want.state_changed, out_data.state_changed);
					check_field("position_cmd", want.position_cmd, out_data.position_cmd);
					check_field("magnets_on", want.magnets_on, out_data.magnets_on);
					check_field("torque_off", want.torque_off, out_data.torque_off);
					check_field("dropoff_request", want.dropoff_request,
						out_data.dropoff_request);
					check_field("closed_now", want.closed_now, out_data.closed_now);
					check_field("infeed_stop", want.infeed_stop, out_data.infeed_stop);
				end
			end
			if (in_valid && in_ready) begin
				n_ticks++;
				predicted = flap_tick(in_data);
				pending_status.push_back(req_typed ? req_exp : predicted);
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int   run_left;
		int   k;
		logic level;
		run_left  = 0;
		level     = 1'b1;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready = 1'b0;
				repeat (HOLDOFF_CYC - 1) @(negedge clk);
				stall_req = 1'b0;
				run_left  = 0;
			end else begin
				if (run_left == 0) begin
					k = $urandom_range(0, 99);
					if (k < 60) begin
						level    = 1'b1;
						run_left = $urandom_range(1, 8);
					end else if (k < 70) begin
						level    = 1'b1;
						run_left = $urandom_range(20, 80);
					end else if (k < 95) begin
						level    = 1'b0;
						run_left = $urandom_range(1, 3);
					end else begin
						level    = 1'b0;
						run_left = $urandom_range(10, 40);
					end
				end
				out_ready = level;
				run_left--;
			end
		end
	end

	function automatic int sender_gap();
		int k;
		if (gap_burst > 0) begin
			gap_burst--;
			return 0;
		end
		k = $urandom_range(0, 99);
		if (k < 5) begin
			gap_burst = $urandom_range(20, 60);
			return 0;
		end
		if (k < 55)
			return 0;
		if (k < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random tick around the current thresholds, with occasional full-range values
	function automatic in_t random_tick();
		in_t r;
		int  k;
		k = $urandom_range(0, 99);
		if (k < 60)
			sim_ms = sim_ms + $urandom_range(0, 150);
		else if (k < 85)
			sim_ms = sim_ms + $urandom_range(150, 1200);
		else if (k < 95)
			sim_ms = sim_ms + $urandom_range(1200, 70000);
		else if (k < 98)
			sim_ms = $urandom;
		else
			sim_ms = sim_ms - $urandom_range(0, 50);
		r.now_ms = sim_ms;

		k = $urandom_range(0, 99);
		if (k < 35)
			r.switch_hold_ms = $urandom_range(0, cfg_m.close_detect_ms);
		else if (k < 45)
			r.switch_hold_ms = cfg_m.close_detect_ms;
		else if (k < 55)
			r.switch_hold_ms = cfg_m.close_detect_ms + 32'd1;
		else if (k < 85)
			r.switch_hold_ms = cfg_m.close_detect_ms + $urandom_range(1, 500);
		else
			r.switch_hold_ms = $urandom;

		r.edge_now    = ($urandom_range(0, 99) < 45) ? EDGE_FEED : 2'($urandom_range(0, 3));
		r.edge_before = ($urandom_range(0, 99) < 40) ? EDGE_FEED : 2'($urandom_range(0, 3));
		r.motor_mode  = ($urandom_range(0, 99) < 50) ? MOTOR_RUNNING :
			3'($urandom_range(0, 7));

		k = $urandom_range(0, 99);
		if (k < 30)
			r.sweep_ms = cfg_m.sweep_threshold_ms + $urandom_range(1, 200);
		else if (k < 45)
			r.sweep_ms = cfg_m.sweep_threshold_ms;
		else if (k < 60)
			r.sweep_ms = $urandom;
		else
			r.sweep_ms = $urandom_range(0, cfg_m.sweep_threshold_ms);

		r.station_now  = ($urandom_range(0, 99) < 25) ? cfg_m.drop_station :
			8'($urandom_range(0, 255));
		r.system_error = ($urandom_range(0, 99) < 3);
		r.flap_error   = ($urandom_range(0, 99) < 3);
		return r;
	endfunction

	function automatic in_t mk(input logic [31:0] now, input logic [31:0] hold,
			input logic [1:0] en, input logic [1:0] eb, input logic [2:0] mot,
			input logic [31:0] sw, input logic [7:0] stn, input logic se, input logic fe);
		in_t r;
		r = '{now, hold, en, eb, mot, sw, stn, se, fe};
		return r;
	endfunction

	function automatic out_t ex(input state_t s, input logic chg, input logic [1:0] pos,
			input logic mag, input logic torq, input logic drop, input logic cl,
			input logic inf);
		out_t o;
		o = '{s, chg, pos, mag, torq, drop, cl, inf};
		return o;
	endfunction

	task automatic send_req(input in_t r, input logic typed, input out_t exp_v,
			input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  = 1'b1;
		in_data   = r;
		req_typed = typed;
		req_exp   = exp_v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop offering and let every pending result come back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		n_cfg++;
		case (idx)
			CFG_DROP_STATION:    cfg_m.drop_station       = val[7:0];
			CFG_OPEN_TIMEOUT:    cfg_m.open_timeout_ms    = val;
			CFG_CLOSE_DETECT:    cfg_m.close_detect_ms    = val;
			CFG_SWEEP_THRESH:    cfg_m.sweep_threshold_ms = val;
			CFG_CARRIER_OPEN:    cfg_m.carrier_open_ms    = val;
			CFG_CLOSING_TIMEOUT: cfg_m.closing_timeout_ms = val;
			default: ;
		endcase
	endtask

	task automatic cfg_program(input cfg_t c);
		cfg_write(CFG_DROP_STATION, {8'd0, c.drop_station});
		cfg_write(CFG_OPEN_TIMEOUT, c.open_timeout_ms);
		cfg_write(CFG_CLOSE_DETECT, c.close_detect_ms);
		cfg_write(CFG_SWEEP_THRESH, c.sweep_threshold_ms);
		cfg_write(CFG_CARRIER_OPEN, c.carrier_open_ms);
		cfg_write(CFG_CLOSING_TIMEOUT, c.closing_timeout_ms);
	endtask

	initial begin : stim
		cfg_t c;
		int   p;
		int   i;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		req_typed   = 1'b0;
		req_exp     = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		stall_req   = 1'b0;
		sim_ms      = '0;
		gap_burst   = 0;
		n_fail      = 0;
		n_ticks     = 0;
		n_results   = 0;
		n_cfg       = 0;
		states_seen = '0;

		cfg_m = '{RST_DROP_STATION, RST_OPEN_TIMEOUT, RST_CLOSE_DETECT, RST_SWEEP_THRESH,
			RST_CARRIER_OPEN, RST_CLOSING_TIMEOUT};
		m_state     = ST_STOP;
		m_infeed    = 1'b0;
		m_open_t    = '0;
		m_opening_t = '0;
		m_pos       = POS_UNKNOWN;
		m_mag       = 1'b1;
		m_torq      = 1'b0;
		m_drop      = 1'b0;

		// directed walk under reset configuration
		dir_tab.push_back('{mk(0, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0), 1'b1,
			ex(ST_STOP, 0, POS_UNKNOWN, 1, 0, 0, 0, 0)});
		dir_tab.push_back('{mk(5, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 1), 1'b1,
			ex(ST_ERROR, 1, POS_UNKNOWN, 1, 1, 0, 0, 0)});
		dir_tab.push_back('{mk(6, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 1, 0), 1'b1,
			ex(ST_STOP, 1, POS_UNKNOWN, 1, 1, 0, 0, 0)});
		dir_tab.push_back('{mk('1, '1, EDGE_NONE, EDGE_NONE, MOTOR_ERROR, '1, '1, 1, 0),
			1'b1, ex(ST_STOP, 0, POS_UNKNOWN, 1, 1, 0, 1, 0)});
		dir_tab.push_back('{mk(2000, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b1, ex(ST_CLOSING, 1, POS_CLOSED, 1, 1, 0, 0, 0)});
		dir_tab.push_back('{mk(2001, RST_CLOSE_DETECT + 1, EDGE_NONE, EDGE_NONE,
			MOTOR_STOP, 0, 0, 0, 0), 1'b1, ex(ST_CLOSED_EMPTY, 1, POS_CLOSED, 1, 1, 1, 1, 0)});
		dir_tab.push_back('{mk(2002, RST_CLOSE_DETECT + 1, EDGE_FEED, EDGE_NONE,
			MOTOR_RUNNING, RST_SWEEP_THRESH + 1, 0, 0, 0), 1'b1,
			ex(ST_CLOSED_PACKET, 1, POS_CLOSED, 1, 1, 1, 1, 1)});
		// threshold equality must not trip anything
		dir_tab.push_back('{mk(2003, RST_CLOSE_DETECT, EDGE_FEED, EDGE_FEED, MOTOR_RUNNING,
			RST_SWEEP_THRESH, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk(3000, 0, EDGE_FEED, EDGE_FEED, MOTOR_STOP, 0,
			RST_DROP_STATION, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk(3300, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(3301, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(4000, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(4001, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(4002, 0, EDGE_MAIN, EDGE_FEED, MOTOR_SWEEPING, 0, 0, 0, 0),
			1'b0, '0});
		// unused edge and motor codes
		dir_tab.push_back('{mk(4003, 51, EDGE_UNUSED, EDGE_UNUSED, MOTOR_UNUSED_B, '1, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(4004, 51, EDGE_FEED, EDGE_NONE, MOTOR_UNUSED_A, 500, 0,
			0, 0), 1'b0, '0});
		dir_tab.push_back('{mk(4005, 51, EDGE_FEED, EDGE_NONE, MOTOR_RUNNING, 500, 0,
			1, 0), 1'b0, '0});
		// clock behind the open time: difference wraps
		dir_tab.push_back('{mk(100, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(101, '1, EDGE_FEED, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(102, '1, EDGE_MAIN, EDGE_FEED, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(103, 0, EDGE_NONE, EDGE_NONE, MOTOR_ERROR, 0, 0, 1, 1),
			1'b0, '0});
		dir_tab.push_back('{mk(104, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(3400, 51, EDGE_FEED, EDGE_FEED, MOTOR_RUNNING, 200, 0, 0, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(3401, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0, 0, 1, 0),
			1'b0, '0});
		dir_tab.push_back('{mk(3402, 0, EDGE_NONE, EDGE_NONE, MOTOR_STOP, 0,
			RST_DROP_STATION, 0, 0), 1'b0, '0});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < dir_tab.size(); i++)
			send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].exp, sender_gap());

		for (p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0: c = '0;
				1: c = '1;
				2: c = '{RST_DROP_STATION, RST_OPEN_TIMEOUT, RST_CLOSE_DETECT,
					RST_SWEEP_THRESH, RST_CARRIER_OPEN, RST_CLOSING_TIMEOUT};
				default: c = '{8'($urandom_range(0, 255)), 16'($urandom_range(0, 1500)),
					16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
					16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500))};
			endcase
			cfg_program(c);
			// one phase runs against a stalled result side
			if (p == 3)
				stall_req = 1'b1;
			repeat (PHASE_TICKS)
				send_req(random_tick(), 1'b0, '0, sender_gap());
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks (%0d directed) under %0d settings, %0d register writes",
			n_ticks, dir_tab.size(), N_PHASES + 1, n_cfg);
		$display("%0d results compared, flap states reached (one bit per state): %b",
			n_results, states_seen);
		if (n_fail == 0) begin
			$display("tb_flap_actuator_state_controller passed");
		end else begin
			$display("%0d field mismatches", n_fail);
			$display("tb_flap_actuator_state_controller failed");
		end
		$finish;
	end

endmodule
